// ===== rtl/thb_pkg.sv =====
// Shared types and constants for the timestamped history buffer.
// Holds the command and status codes, the sequencer state type and the frame record.
// No dependencies; every other file of the block imports this package.
package thb_pkg;

	// Default ring depth in frames.
	localparam int DEPTH_DEF = 64;

	// Fixed field widths at the ports.
	localparam int TIME_W   = 32;
	localparam int TAG_W    = 32;
	localparam int CMD_W    = 3;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 7;

	// Command codes of a request.
	localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_NEAREST = 3'd1;
	localparam logic [CMD_W-1:0] CMD_WINDOW  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_NEXT    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ALL     = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd5;

	// Status codes of a result.
	localparam logic [STATUS_W-1:0] STAT_FOUND    = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_NONE     = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_PUSHED   = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_PUSH_OVF = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_REJECT   = 3'd4;
	localparam logic [STATUS_W-1:0] STAT_CLEARED  = 3'd5;

	// One stored frame: timestamp and tag side by side in the memory.
	typedef struct packed {
		logic [TIME_W-1:0] frame_time;
		logic [TAG_W-1:0]  frame_tag;
	} frame_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_PUSH,
		S_EV_CHECK,
		S_EV_WAIT,
		S_SRCH,
		S_CMP,
		S_NEAR_B,
		S_NEAR_A,
		S_RANGE,
		S_EMIT,
		S_REPLY
	} thb_state_t;

endpackage

// ===== rtl/thb_frame_mem.sv =====
// Frame store of the history buffer: one write port and one registered read port.
// Each entry holds a timestamp and a tag as one frame_t word.
// Depends on thb_pkg for the frame record type.
module thb_frame_mem
	import thb_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  frame_t        wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output frame_t        rd_data
);

	frame_t mem [DEPTH];
	frame_t rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/timestamped_history_buffer.sv =====
// Timestamped history buffer: a time-ordered ring of up to DEPTH frames (timestamp and tag)
// held in a frame memory with one registered read port, answering push, nearest, window,
// next-after, all-after and clear requests. One request is worked at a time. A push writes
// the frame, first dropping the oldest frame when the ring is full, then evicts oldest frames
// one at a time, each with a read of the new oldest frame, to keep the span within span_max.
// A query is accepted, then runs a binary search that reads the midpoint and narrows the
// interval at each halving step; a window query runs the search twice. A nearest query whose
// target falls between two frames reads both and compares them. The query then starts its
// run and returns the matching frames one by one, or a single none-found result. Clear,
// rejected, unknown and empty-ring nearest requests go straight to their single result. A
// stalled result channel holds the sequencer until the result register is free. Every search
// step and every result goes through the one read port of the frame memory.
// Every result carries the entry count and the oldest and newest kept times after the request.
module timestamped_history_buffer
	import thb_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// Request channel.
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [CMD_W-1:0]    cmd,
	input  logic [TIME_W-1:0]   time_value,
	input  logic [TIME_W-1:0]   half_span,
	input  logic [TAG_W-1:0]    frame_tag,
	// Result channel.
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [TIME_W-1:0]   found_time,
	output logic [TAG_W-1:0]    found_tag,
	output logic [COUNT_W-1:0]  evicted_count,
	output logic                last,
	output logic [COUNT_W-1:0]  entry_count,
	output logic [TIME_W-1:0]   earliest_time,
	output logic [TIME_W-1:0]   latest_time,
	// Configuration write channel.
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [TIME_W-1:0]   span_max
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// Physical slot of a logical index counted from the oldest frame.
	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
			input logic [CW-1:0] idx);
		logic [CW:0] sum;
		sum = (CW+1)'(base) + (CW+1)'(idx);
		if (sum >= (CW+1)'(DEPTH)) begin
			sum = sum - (CW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	// Next slot around the ring.
	function automatic logic [AW-1:0] inc_slot(input logic [AW-1:0] slot);
		return (slot == AW'(DEPTH - 1)) ? '0 : slot + 1'b1;
	endfunction

	// Control registers.
	thb_state_t          state_q, state_d;
	logic [CW-1:0]       count_q, count_d;
	logic [AW-1:0]       oldest_slot_q, oldest_slot_d;
	logic [TIME_W-1:0]   max_dur_q, max_dur_d;
	logic                out_valid_q, out_valid_d;

	// Working registers of the current request.
	logic [TIME_W-1:0]   earliest_time_q, earliest_time_d;
	logic [TIME_W-1:0]   latest_time_q, latest_time_d;
	logic [CMD_W-1:0]    cmd_q, cmd_d;
	logic [TIME_W-1:0]   key_q, key_d;
	logic [TAG_W-1:0]    tag_q, tag_d;
	logic [TIME_W-1:0]   bound_hi_q, bound_hi_d;
	logic                phase_q, phase_d;
	logic [CW-1:0]       lo_q, lo_d;
	logic [CW-1:0]       hi_q, hi_d;
	logic [CW-1:0]       mid_q, mid_d;
	logic [CW-1:0]       from_q, from_d;
	logic [CW-1:0]       end_q, end_d;
	logic [TIME_W-1:0]   near_b_q, near_b_d;
	logic [CW-1:0]       ev_q, ev_d;
	logic                ovf_q, ovf_d;
	logic [STATUS_W-1:0] rep_status_q, rep_status_d;
	logic                rep_frame_q, rep_frame_d;

	// Output registers.
	logic [STATUS_W-1:0] status_q;
	logic [TIME_W-1:0]   found_time_q;
	logic [TAG_W-1:0]    found_tag_q;
	logic [COUNT_W-1:0]  evicted_q;
	logic                last_q;
	logic [COUNT_W-1:0]  entry_count_q;
	logic [TIME_W-1:0]   oldest_out_q;
	logic [TIME_W-1:0]   newest_out_q;

	// Result load strobe and values.
	logic                out_load;
	logic                out_free;
	logic [STATUS_W-1:0] ld_status;
	logic [TIME_W-1:0]   ld_time;
	logic [TAG_W-1:0]    ld_tag;
	logic [CW-1:0]       ld_ev;
	logic                ld_last;

	// Memory requests.
	logic                wr_en;
	logic [AW-1:0]       wr_slot;
	frame_t              wr_data;
	logic                rd_en;
	logic [AW-1:0]       rd_slot;
	frame_t              rd_data;

	// Helpers.
	logic [TIME_W-1:0]   win_lo;
	logic [TIME_W:0]     win_sum;
	logic [TIME_W-1:0]   win_hi;
	logic [CW-1:0]       mid;
	logic                srch_strict;
	logic                before_key;
	logic                full;
	logic                pick_lower;
	logic                emit_last;

	thb_frame_mem #(
		.DEPTH (DEPTH)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_slot),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_slot),
		.rd_data (rd_data)
	);

	// Window bounds, saturating at both ends of the time range.
	assign win_lo  = (time_value >= half_span) ? time_value - half_span : '0;
	assign win_sum = {1'b0, time_value} + {1'b0, half_span};
	assign win_hi  = win_sum[TIME_W] ? '1 : win_sum[TIME_W-1:0];

	// Search step: midpoint and order test against the key.
	assign mid         = lo_q + ((hi_q - lo_q) >> 1);
	assign srch_strict = (cmd_q == CMD_NEAREST) ? 1'b0 :
	                     (cmd_q == CMD_WINDOW)  ? phase_q : 1'b1;
	assign before_key  = srch_strict ? (rd_data.frame_time <= key_q)
	                                 : (rd_data.frame_time < key_q);

	assign full       = (count_q == CW'(DEPTH));
	assign pick_lower = (key_q - rd_data.frame_time) <= (near_b_q - key_q);
	assign emit_last  = ((from_q + 1'b1) == end_q);
	assign out_free   = !out_valid_q || !out_stall;

	// Sequencer: next state, memory requests and register updates.
	always_comb begin
		state_d         = state_q;
		count_d         = count_q;
		oldest_slot_d   = oldest_slot_q;
		max_dur_d       = max_dur_q;
		earliest_time_d = earliest_time_q;
		latest_time_d   = latest_time_q;
		cmd_d           = cmd_q;
		key_d           = key_q;
		tag_d           = tag_q;
		bound_hi_d      = bound_hi_q;
		phase_d         = phase_q;
		lo_d            = lo_q;
		hi_d            = hi_q;
		mid_d           = mid_q;
		from_d          = from_q;
		end_d           = end_q;
		near_b_d        = near_b_q;
		ev_d            = ev_q;
		ovf_d           = ovf_q;
		rep_status_d    = rep_status_q;
		rep_frame_d     = rep_frame_q;
		wr_en           = 1'b0;
		wr_slot         = '0;
		wr_data         = '{frame_time: key_q, frame_tag: tag_q};
		rd_en           = 1'b0;
		rd_slot         = '0;
		out_load        = 1'b0;
		ld_status       = STAT_NONE;
		ld_time         = '0;
		ld_tag          = '0;
		ld_ev           = '0;
		ld_last         = 1'b0;

		if (cfg_valid) begin
			max_dur_d = span_max;
		end

		case (state_q)
			// Take a request and decide how it is worked.
			S_IDLE: begin
				ev_d  = '0;
				ovf_d = 1'b0;
				if (in_valid) begin
					cmd_d        = cmd;
					key_d        = time_value;
					tag_d        = frame_tag;
					rep_frame_d  = 1'b0;
					rep_status_d = STAT_NONE;
					lo_d         = '0;
					hi_d         = count_q;
					phase_d      = 1'b0;
					case (cmd)
						CMD_PUSH: begin
							if (count_q != '0 && time_value < latest_time_q) begin
								rep_status_d = STAT_REJECT;
								state_d      = S_REPLY;
							end else begin
								state_d = S_PUSH;
							end
						end
						CMD_NEAREST: begin
							state_d = (count_q == '0) ? S_REPLY : S_SRCH;
						end
						CMD_WINDOW: begin
							key_d      = win_lo;
							bound_hi_d = win_hi;
							state_d    = S_SRCH;
						end
						CMD_NEXT, CMD_ALL: begin
							state_d = S_SRCH;
						end
						CMD_CLEAR: begin
							count_d       = '0;
							oldest_slot_d = '0;
							rep_status_d  = STAT_CLEARED;
							state_d       = S_REPLY;
						end
						default: begin
							state_d = S_REPLY;
						end
					endcase
				end
			end

			// Append the frame; a full ring drops its oldest frame first.
			S_PUSH: begin
				wr_en         = 1'b1;
				latest_time_d = key_q;
				if (full) begin
					wr_slot       = oldest_slot_q;
					oldest_slot_d = inc_slot(oldest_slot_q);
					ev_d          = CW'(1);
					ovf_d         = 1'b1;
					rd_en         = 1'b1;
					rd_slot       = inc_slot(oldest_slot_q);
					state_d       = S_EV_WAIT;
				end else begin
					wr_slot = slot_of(oldest_slot_q, count_q);
					count_d = count_q + 1'b1;
					if (count_q == '0) begin
						earliest_time_d = key_q;
					end
					state_d = S_EV_CHECK;
				end
			end

			// Evict the oldest frame while the span exceeds the limit.
			S_EV_CHECK: begin
				if (count_q > CW'(1) && (key_q - earliest_time_q) > max_dur_q) begin
					oldest_slot_d = inc_slot(oldest_slot_q);
					count_d       = count_q - 1'b1;
					ev_d          = ev_q + 1'b1;
					rd_en         = 1'b1;
					rd_slot       = inc_slot(oldest_slot_q);
					state_d       = S_EV_WAIT;
				end else begin
					rep_status_d = ovf_q ? STAT_PUSH_OVF : STAT_PUSHED;
					rep_frame_d  = 1'b1;
					state_d      = S_REPLY;
				end
			end

			// Pick up the time of the new oldest frame.
			S_EV_WAIT: begin
				earliest_time_d = rd_data.frame_time;
				state_d         = S_EV_CHECK;
			end

			// Binary search: read the midpoint, or hand the result on.
			S_SRCH: begin
				if (lo_q < hi_q) begin
					rd_en   = 1'b1;
					rd_slot = slot_of(oldest_slot_q, mid);
					mid_d   = mid;
					state_d = S_CMP;
				end else begin
					case (cmd_q)
						CMD_NEAREST: begin
							if (lo_q >= count_q) begin
								from_d  = count_q - 1'b1;
								end_d   = count_q;
								state_d = S_RANGE;
							end else if (lo_q == '0) begin
								from_d  = '0;
								end_d   = CW'(1);
								state_d = S_RANGE;
							end else begin
								rd_en   = 1'b1;
								rd_slot = slot_of(oldest_slot_q, lo_q);
								state_d = S_NEAR_B;
							end
						end
						CMD_WINDOW: begin
							if (!phase_q) begin
								from_d  = lo_q;
								phase_d = 1'b1;
								key_d   = bound_hi_q;
								lo_d    = '0;
								hi_d    = count_q;
							end else begin
								end_d   = lo_q;
								state_d = S_RANGE;
							end
						end
						CMD_NEXT: begin
							from_d  = lo_q;
							end_d   = (lo_q < count_q) ? lo_q + 1'b1 : lo_q;
							state_d = S_RANGE;
						end
						default: begin
							from_d  = lo_q;
							end_d   = count_q;
							state_d = S_RANGE;
						end
					endcase
				end
			end

			// Narrow the search interval.
			S_CMP: begin
				if (before_key) begin
					lo_d = mid_q + 1'b1;
				end else begin
					hi_d = mid_q;
				end
				state_d = S_SRCH;
			end

			// Nearest: keep the later candidate, then read the earlier one.
			S_NEAR_B: begin
				near_b_d = rd_data.frame_time;
				rd_en    = 1'b1;
				rd_slot  = slot_of(oldest_slot_q, lo_q - 1'b1);
				state_d  = S_NEAR_A;
			end

			// Nearest: a tie goes to the earlier frame.
			S_NEAR_A: begin
				from_d  = pick_lower ? lo_q - 1'b1 : lo_q;
				end_d   = pick_lower ? lo_q : lo_q + 1'b1;
				state_d = S_RANGE;
			end

			// Start a run of results, or report that none matched.
			S_RANGE: begin
				if (from_q >= end_q) begin
					rep_status_d = STAT_NONE;
					state_d      = S_REPLY;
				end else begin
					rd_en   = 1'b1;
					rd_slot = slot_of(oldest_slot_q, from_q);
					state_d = S_EMIT;
				end
			end

			// One matching frame per cycle while the output takes them.
			S_EMIT: begin
				if (out_free) begin
					out_load  = 1'b1;
					ld_status = STAT_FOUND;
					ld_time   = rd_data.frame_time;
					ld_tag    = rd_data.frame_tag;
					ld_last   = emit_last;
					from_d    = from_q + 1'b1;
					if (emit_last) begin
						state_d = S_IDLE;
					end else begin
						rd_en   = 1'b1;
						rd_slot = slot_of(oldest_slot_q, from_q + 1'b1);
					end
				end
			end

			// Single closing result of a request.
			S_REPLY: begin
				if (out_free) begin
					out_load  = 1'b1;
					ld_status = rep_status_q;
					ld_time   = rep_frame_q ? key_q : '0;
					ld_tag    = rep_frame_q ? tag_q : '0;
					ld_ev     = ev_q;
					ld_last   = 1'b1;
					state_d   = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase

		// Output register handshake.
		if (out_load) begin
			out_valid_d = 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	// Control state with reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			oldest_slot_q <= '0;
			max_dur_q     <= '1;
			out_valid_q   <= 1'b0;
		end else begin
			state_q       <= state_d;
			count_q       <= count_d;
			oldest_slot_q <= oldest_slot_d;
			max_dur_q     <= max_dur_d;
			out_valid_q   <= out_valid_d;
		end
	end

	// Working registers of the request.
	always_ff @(posedge clk) begin
		earliest_time_q <= earliest_time_d;
		latest_time_q   <= latest_time_d;
		cmd_q           <= cmd_d;
		key_q           <= key_d;
		tag_q           <= tag_d;
		bound_hi_q      <= bound_hi_d;
		phase_q         <= phase_d;
		lo_q            <= lo_d;
		hi_q            <= hi_d;
		mid_q           <= mid_d;
		from_q          <= from_d;
		end_q           <= end_d;
		near_b_q        <= near_b_d;
		ev_q            <= ev_d;
		ovf_q           <= ovf_d;
		rep_status_q    <= rep_status_d;
		rep_frame_q     <= rep_frame_d;
	end

	// Result payload, loaded with the ring summary as it stands now.
	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q      <= ld_status;
			found_time_q  <= ld_time;
			found_tag_q   <= ld_tag;
			evicted_q     <= COUNT_W'(ld_ev);
			last_q        <= ld_last;
			entry_count_q <= COUNT_W'(count_q);
			oldest_out_q  <= (count_q != '0) ? earliest_time_q : '0;
			newest_out_q  <= (count_q != '0) ? latest_time_q : '0;
		end
	end

	assign in_stall      = (state_q != S_IDLE);
	assign cfg_ready     = 1'b1;
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign found_time    = found_time_q;
	assign found_tag     = found_tag_q;
	assign evicted_count = evicted_q;
	assign last          = last_q;
	assign entry_count   = entry_count_q;
	assign earliest_time = oldest_out_q;
	assign latest_time   = newest_out_q;

endmodule

// ===== verif/timestamped_history_buffer_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the timestamped history buffer: directed and random requests,
// with replies checked against a frame ring tracked in the testbench. Depends on thb_pkg
// and the timestamped_history_buffer RTL only.
module timestamped_history_buffer_tb;
	import thb_pkg::*;

	localparam int RING_DEPTH = DEPTH_DEF;

	// Command codes the block answers with a plain "none found".
	localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	// One reply as it appears on the result channel.
	typedef struct packed {
		logic [STATUS_W-1:0] code;
		logic [TIME_W-1:0]   ftime;
		logic [TAG_W-1:0]    ftag;
		logic [COUNT_W-1:0]  evicted;
		logic                is_last;
		logic [COUNT_W-1:0]  entries;
		logic [TIME_W-1:0]   oldest;
		logic [TIME_W-1:0]   newest;
	} reply_t;

	// Tracks the frame ring and the replies each accepted request must produce.
	class frame_history;
		logic [TIME_W-1:0] slot_time [RING_DEPTH];
		logic [TAG_W-1:0]  slot_tag  [RING_DEPTH];
		int unsigned       head_slot;
		int unsigned       held;
		logic [TIME_W-1:0] span_limit;
		reply_t            predicted_replies [$];
		int unsigned       errors;

		function new();
			head_slot = 0;
			held = 0;
			span_limit = '1;
			errors = 0;
		endfunction

		function logic [TIME_W-1:0] time_at(int unsigned i);
			return slot_time[(head_slot + i) % RING_DEPTH];
		endfunction

		function logic [TIME_W-1:0] oldest();
			return (held != 0) ? time_at(0) : '0;
		endfunction

		function logic [TIME_W-1:0] newest();
			return (held != 0) ? time_at(held - 1) : '0;
		endfunction

		function int unsigned pending();
			return predicted_replies.size();
		endfunction

		// First held frame at or after t, or strictly after t when strict is set.
		function int unsigned first_from(logic [TIME_W-1:0] t, bit strict);
			for (int unsigned i = 0; i < held; i++)
				if (strict ? (time_at(i) > t) : (time_at(i) >= t))
					return i;
			return held;
		endfunction

		function void add_reply(logic [STATUS_W-1:0] code, logic [TIME_W-1:0] ftime,
				logic [TAG_W-1:0] ftag, int unsigned evicted, bit is_last);
			reply_t r;
			r.code = code;
			r.ftime = ftime;
			r.ftag = ftag;
			r.evicted = evicted[COUNT_W-1:0];
			r.is_last = is_last;
			r.entries = held[COUNT_W-1:0];
			r.oldest = oldest();
			r.newest = newest();
			predicted_replies.insert(predicted_replies.size(), r);
		endfunction

		// One reply per held frame in [from, upto), or a single "none found".
		function void add_frames(int unsigned from, int unsigned upto);
			int unsigned s;
			if (from >= upto) begin
				add_reply(STAT_NONE, '0, '0, 0, 1'b1);
				return;
			end
			for (int unsigned i = from; i < upto; i++) begin
				s = (head_slot + i) % RING_DEPTH;
				add_reply(STAT_FOUND, slot_time[s], slot_tag[s], 0, (i + 1 == upto));
			end
		endfunction

		function void note_request(logic [CMD_W-1:0] c, logic [TIME_W-1:0] t,
				logic [TIME_W-1:0] hw, logic [TAG_W-1:0] tag);
			int unsigned       slot;
			int unsigned       idx;
			int unsigned       evicted;
			bit                overflow;
			logic [TIME_W-1:0] low_bound;
			logic [TIME_W-1:0] high_bound;
			case (c)
				CMD_PUSH: begin
					if (held > 0 && t < newest()) begin
						add_reply(STAT_REJECT, '0, '0, 0, 1'b1);
					end else begin
						evicted = 0;
						overflow = 1'b0;
						// A full ring drops its oldest frame before the append.
						if (held >= RING_DEPTH) begin
							head_slot = (head_slot + 1) % RING_DEPTH;
							held--;
							evicted++;
							overflow = 1'b1;
						end
						slot = (head_slot + held) % RING_DEPTH;
						slot_time[slot] = t;
						slot_tag[slot] = tag;
						held++;
						// Trim from the old end until the span fits.
						while (held > 1 && (t - time_at(0)) > span_limit) begin
							head_slot = (head_slot + 1) % RING_DEPTH;
							held--;
							evicted++;
						end
						add_reply(overflow ? STAT_PUSH_OVF : STAT_PUSHED, t, tag, evicted, 1'b1);
					end
				end
				CMD_NEAREST: begin
					if (held == 0) begin
						add_reply(STAT_NONE, '0, '0, 0, 1'b1);
					end else begin
						idx = first_from(t, 1'b0);
						// On equal distance the earlier frame wins.
						if (idx >= held)
							idx = held - 1;
						else if (idx > 0 && (t - time_at(idx - 1)) <= (time_at(idx) - t))
							idx = idx - 1;
						slot = (head_slot + idx) % RING_DEPTH;
						add_reply(STAT_FOUND, slot_time[slot], slot_tag[slot], 0, 1'b1);
					end
				end
				CMD_WINDOW: begin
					// Window bounds saturate at both ends of the tick range.
					low_bound = (t >= hw) ? t - hw : '0;
					high_bound = (hw > ('1 - t)) ? '1 : t + hw;
					add_frames(first_from(low_bound, 1'b0), first_from(high_bound, 1'b1));
				end
				CMD_NEXT: begin
					idx = first_from(t, 1'b1);
					add_frames(idx, (idx < held) ? idx + 1 : idx);
				end
				CMD_ALL: begin
					add_frames(first_from(t, 1'b1), held);
				end
				CMD_CLEAR: begin
					head_slot = 0;
					held = 0;
					add_reply(STAT_CLEARED, '0, '0, 0, 1'b1);
				end
				default: begin
					add_reply(STAT_NONE, '0, '0, 0, 1'b1);
				end
			endcase
		endfunction

		function int unsigned field_differs(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
				return 1;
			end
			return 0;
		endfunction

		function void check_reply(reply_t got);
			reply_t want;
			if (predicted_replies.size() == 0) begin
				$display("%0t: reply with no request pending, status %0d time 0x%0h",
					$time, got.code, got.ftime);
				errors++;
				return;
			end
			want = predicted_replies[0];
			predicted_replies.delete(0);
			errors += field_differs("status", 32'(want.code), 32'(got.code));
			errors += field_differs("found_time", want.ftime, got.ftime);
			errors += field_differs("found_tag", want.ftag, got.ftag);
			errors += field_differs("evicted_count", 32'(want.evicted), 32'(got.evicted));
			errors += field_differs("last", 32'(want.is_last), 32'(got.is_last));
			errors += field_differs("entry_count", 32'(want.entries), 32'(got.entries));
			errors += field_differs("earliest_time", want.oldest, got.oldest);
			errors += field_differs("latest_time", want.newest, got.newest);
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [CMD_W-1:0]    cmd = '0;
	logic [TIME_W-1:0]   time_value = '0;
	logic [TIME_W-1:0]   half_span = '0;
	logic [TAG_W-1:0]    frame_tag = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [TIME_W-1:0]   found_time;
	logic [TAG_W-1:0]    found_tag;
	logic [COUNT_W-1:0]  evicted_count;
	logic                last;
	logic [COUNT_W-1:0]  entry_count;
	logic [TIME_W-1:0]   earliest_time;
	logic [TIME_W-1:0]   latest_time;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [TIME_W-1:0]   span_max = '0;

	frame_history history;
	reply_t       seen_reply;
	int unsigned  sender_idle_pct = 0;
	int unsigned  stall_pct = 0;

	timestamped_history_buffer #(
		.DEPTH(RING_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.time_value(time_value),
		.half_span(half_span),
		.frame_tag(frame_tag),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.found_time(found_time),
		.found_tag(found_tag),
		.evicted_count(evicted_count),
		.last(last),
		.entry_count(entry_count),
		.earliest_time(earliest_time),
		.latest_time(latest_time),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.span_max(span_max)
	);

	// 8 ns clock.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Random back-pressure on the result channel.
	always @(posedge clk) begin
		out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
	end

	// Check every reply taken from the result channel.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen_reply.code = status;
			seen_reply.ftime = found_time;
			seen_reply.ftag = found_tag;
			seen_reply.evicted = evicted_count;
			seen_reply.is_last = last;
			seen_reply.entries = entry_count;
			seen_reply.oldest = earliest_time;
			seen_reply.newest = latest_time;
			history.check_reply(seen_reply);
		end
	end

	task automatic set_idling(idle_mode_t mode);
		case (mode)
			IDLE_SENDER: begin
				sender_idle_pct = 58;
				stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				sender_idle_pct = 0;
				stall_pct = 58;
			end
			IDLE_BOTH: begin
				sender_idle_pct = 25;
				stall_pct = 25;
			end
			default: begin
				sender_idle_pct = 0;
				stall_pct = 0;
			end
		endcase
	endtask

	// Offer one request, with random idle cycles ahead of it, and note it once taken.
	task automatic send_request(logic [CMD_W-1:0] c, logic [TIME_W-1:0] t,
			logic [TIME_W-1:0] hw, logic [TAG_W-1:0] tag);
		while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		time_value <= t;
		half_span <= hw;
		frame_tag <= tag;
		do
			@(posedge clk);
		while (in_stall);
		history.note_request(c, t, hw, tag);
	endtask

	// Hold off new requests until every predicted reply has come back.
	task automatic wait_for_replies();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (history.pending() != 0);
	endtask

	// Change the span limit only while the block is idle.
	task automatic write_span_max(logic [TIME_W-1:0] value);
		wait_for_replies();
		repeat (12) @(posedge clk);
		cfg_valid <= 1'b1;
		span_max <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		history.span_limit = value;
	endtask

	// Query time: mostly near or on held frames, sometimes anywhere.
	function automatic logic [TIME_W-1:0] pick_probe();
		int unsigned       pick;
		logic [TIME_W-1:0] lo;
		logic [TIME_W-1:0] hi;
		pick = $urandom_range(0, 99);
		if (history.held == 0 || pick < 20)
			return $urandom;
		if (pick < 50)
			return history.time_at($urandom_range(0, history.held - 1));
		lo = history.oldest();
		hi = history.newest();
		lo = (lo > 8) ? lo - 8 : '0;
		hi = (hi < 32'hFFFF_FFF7) ? hi + 8 : '1;
		return $urandom_range(hi, lo);
	endfunction

	// In-order push time: a fresh base on an empty ring, else a step past the newest frame.
	function automatic logic [TIME_W-1:0] next_push_time();
		int unsigned     pick;
		logic [TIME_W:0] sum;
		pick = $urandom_range(0, 99);
		if (history.held == 0) begin
			if (pick < 40)
				return $urandom;
			if (pick < 70)
				return $urandom_range(0, 200);
			return 32'hFFFF_FFFF - $urandom_range(0, 5000);
		end
		if (pick < 20)
			sum = {1'b0, history.newest()};
		else if (pick < 80)
			sum = {1'b0, history.newest()} + $urandom_range(1, 40);
		else
			sum = {1'b0, history.newest()} + $urandom_range(41, 100000);
		return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
	endfunction

	// Mostly well-ordered pushes and queries on held frames, plus some noise.
	task automatic random_request();
		int unsigned       pick;
		logic [CMD_W-1:0]  c;
		logic [TIME_W-1:0] t;
		logic [TIME_W-1:0] hw;
		logic [TAG_W-1:0]  tag;
		pick = $urandom_range(0, 99);
		tag = $urandom;
		hw = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 60);
		t = pick_probe();
		if (pick < 45) begin
			c = CMD_PUSH;
			t = next_push_time();
		end else if (pick < 50) begin
			c = CMD_PUSH;
			if (history.held != 0 && history.newest() != 0)
				t = $urandom_range(history.newest() - 1, 0);
			else
				t = $urandom;
		end else if (pick < 62) begin
			c = CMD_NEAREST;
		end else if (pick < 72) begin
			c = CMD_WINDOW;
		end else if (pick < 80) begin
			c = CMD_NEXT;
		end else if (pick < 87) begin
			c = CMD_ALL;
		end else if (pick < 91) begin
			c = CMD_CLEAR;
		end else if (pick < 95) begin
			c = pick[0] ? CMD_UNUSED_HI : CMD_UNUSED_LO;
			t = $urandom;
		end else begin
			c = CMD_W'($urandom_range(0, 7));
			t = $urandom;
			hw = $urandom;
		end
		send_request(c, t, hw, tag);
	endtask

	initial begin
		logic [TIME_W-1:0] duration_steps [8];
		history = new();
		duration_steps[0] = 32'hFFFF_FFFF;
		duration_steps[1] = 32'd20;
		duration_steps[2] = 32'd1000;
		duration_steps[3] = 32'h8000_0000;
		duration_steps[4] = 32'd0;
		duration_steps[5] = $urandom_range(1, 300);
		duration_steps[6] = $urandom;
		duration_steps[7] = 32'hFFFF_FFFE;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests at the reset span limit.
		set_idling(IDLE_NONE);
		send_request(CMD_NEAREST, 32'd10, '0, '0);
		send_request(CMD_WINDOW, 32'd10, 32'd5, '0);
		send_request(CMD_NEXT, '0, '0, '0);
		send_request(CMD_ALL, '0, '0, '0);
		send_request(CMD_UNUSED_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(CMD_UNUSED_HI, '0, '0, '0);
		send_request(CMD_PUSH, 32'd100, '0, 32'hA5A5_0001);
		send_request(CMD_PUSH, 32'd100, '0, 32'hA5A5_0002);
		send_request(CMD_PUSH, 32'd200, '0, 32'hA5A5_0003);
		send_request(CMD_PUSH, 32'd50, '0, 32'hA5A5_0004);
		send_request(CMD_NEAREST, 32'd150, '0, '0);
		send_request(CMD_NEAREST, '0, '0, '0);
		send_request(CMD_NEAREST, 32'hFFFF_FFFF, '0, '0);
		send_request(CMD_WINDOW, '0, 32'hFFFF_FFFF, '0);
		send_request(CMD_WINDOW, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
		send_request(CMD_WINDOW, 32'd150, '0, '0);
		send_request(CMD_WINDOW, 32'd150, 32'd50, '0);
		send_request(CMD_NEXT, 32'd100, '0, '0);
		send_request(CMD_NEXT, 32'd200, '0, '0);
		send_request(CMD_ALL, '0, '0, '0);
		send_request(CMD_PUSH, 32'hFFFF_FFFF, '0, 32'hFFFF_FFFF);
		send_request(CMD_CLEAR, '0, '0, '0);
		send_request(CMD_PUSH, '0, '0, '0);
		send_request(CMD_ALL, '0, '0, '0);

		// Overfill the ring, read it all back, then shrink the span to drop every old frame.
		send_request(CMD_CLEAR, '0, '0, '0);
		for (int i = 0; i < 68; i++)
			send_request(CMD_PUSH, 32'd1000 + (i / 2) * 3, '0, $urandom);
		send_request(CMD_ALL, '0, '0, '0);
		send_request(CMD_NEAREST, 32'd1050, '0, '0);
		send_request(CMD_WINDOW, 32'd1100, 32'd20, '0);
		write_span_max('0);
		send_request(CMD_PUSH, 32'd10000, '0, $urandom);

		// Random phases, each with its own span limit and idling pattern.
		for (int p = 0; p < 8; p++) begin
			write_span_max(duration_steps[p]);
			set_idling(idle_mode_t'(p % 4));
			for (int n = 0; n < 42; n++) begin
				if (p == 2 && n == 21)
					wait_for_replies();
				random_request();
			end
		end

		wait_for_replies();
		repeat (40) @(posedge clk);
		if (history.errors == 0 && history.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#20_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/thb_pkg.sv
rtl/thb_frame_mem.sv
rtl/timestamped_history_buffer.sv
verif/timestamped_history_buffer_tb.sv
